>>> rtl/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg: shared types and constants of the price level book
// defaults for the book parameters, cell opcodes and the control states
// ----------------------------------------------------------------------------
`default_nettype none

package plb_pkg;

  // defaults handed to the top level parameters
  localparam int unsigned MAX_LEVELS_DEF = 32;
  localparam int unsigned PRICE_BITS_DEF = 32;
  localparam int unsigned QTY_BITS_DEF   = 32;

  // fixed widths of the channel fields
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned COUNT_W = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // what every cell of a row does in the apply cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_WRITE,
    OP_DELETE
  } op_t;

  // per-row control word, shared by every cell of the row
  typedef struct packed {
    op_t op;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_REPORT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/plb_cell.sv
// ----------------------------------------------------------------------------
// plb_cell: one price level slot of a sorted row
// holds a level, compares it with the incoming price and shifts with neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module plb_cell #(
  parameter int unsigned PRICE_BITS = plb_pkg::PRICE_BITS_DEF,
  parameter int unsigned QTY_BITS   = plb_pkg::QTY_BITS_DEF,
  parameter bit          ASCEND     = 1'b0
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cmp_en,
  input  wire logic [PRICE_BITS-1:0] cmp_price,
  input  wire logic                  valid,
  input  wire plb_pkg::cell_ctl_t    ctl,
  input  wire logic [PRICE_BITS-1:0] new_price,
  input  wire logic [QTY_BITS-1:0]   new_qty,
  input  wire logic                  prev_ahead,
  input  wire logic [PRICE_BITS-1:0] prev_price,
  input  wire logic [QTY_BITS-1:0]   prev_qty,
  input  wire logic [PRICE_BITS-1:0] next_price,
  input  wire logic [QTY_BITS-1:0]   next_qty,
  output logic [PRICE_BITS-1:0]      price,
  output logic [QTY_BITS-1:0]        qty,
  output logic                       ahead,
  output logic                       eq
);

  logic [PRICE_BITS-1:0] price_r, price_nxt;
  logic [QTY_BITS-1:0]   qty_r, qty_nxt;
  logic                  ahead_r, eq_r;
  logic                  better;

  // ahead: this level sorts strictly before the incoming price
  assign better = ASCEND ? (price_r < cmp_price) : (price_r > cmp_price);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ahead_r <= 1'b0;
      eq_r    <= 1'b0;
    end else if (cmp_en) begin
      ahead_r <= valid & better;
      eq_r    <= valid & (price_r == cmp_price);
    end
  end

  always_comb begin
    price_nxt = price_r;
    qty_nxt   = qty_r;
    case (ctl.op)
      plb_pkg::OP_INSERT: begin
        if (!ahead_r) begin
          if (prev_ahead) begin
            price_nxt = new_price;
            qty_nxt   = new_qty;
          end else begin
            price_nxt = prev_price;
            qty_nxt   = prev_qty;
          end
        end
      end
      plb_pkg::OP_WRITE: begin
        if (eq_r) qty_nxt = new_qty;
      end
      plb_pkg::OP_DELETE: begin
        if (!ahead_r) begin
          price_nxt = next_price;
          qty_nxt   = next_qty;
        end
      end
      default: begin
        price_nxt = price_r;
        qty_nxt   = qty_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    qty_r   <= qty_nxt;
  end

  assign price = price_r;
  assign qty   = qty_r;
  assign ahead = ahead_r;
  assign eq    = eq_r;

endmodule

`default_nettype wire

>>> rtl/plb_side.sv
// ----------------------------------------------------------------------------
// plb_side: one side of the book as a row of level cells
// best level always sits in cell 0; fill count and update decision live here
// ----------------------------------------------------------------------------
`default_nettype none

module plb_side #(
  parameter int unsigned MAX_LEVELS = plb_pkg::MAX_LEVELS_DEF,
  parameter int unsigned PRICE_BITS = plb_pkg::PRICE_BITS_DEF,
  parameter int unsigned QTY_BITS   = plb_pkg::QTY_BITS_DEF,
  parameter bit          ASCEND     = 1'b0,
  localparam int unsigned FILL_BITS = $clog2(MAX_LEVELS + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cmp_en,
  input  wire logic [PRICE_BITS-1:0] cmp_price,
  input  wire logic                  apply_en,
  input  wire logic                  clear,
  input  wire logic [PRICE_BITS-1:0] item_price,
  input  wire logic [QTY_BITS-1:0]   item_qty,
  output logic [FILL_BITS-1:0]       fill,
  output logic [PRICE_BITS-1:0]      best_price,
  output logic [QTY_BITS-1:0]        best_qty,
  output logic                       ovf
);

  logic [FILL_BITS-1:0]  fill_r, fill_nxt;
  plb_pkg::cell_ctl_t    ctl;
  logic [MAX_LEVELS-1:0] ahead_v, eq_v, valid_v;
  logic [PRICE_BITS-1:0] price_v [MAX_LEVELS];
  logic [QTY_BITS-1:0]   qty_v   [MAX_LEVELS];
  logic                  any_eq, full;

  assign any_eq = |eq_v;
  assign full   = (fill_r == FILL_BITS'(MAX_LEVELS));

  always_comb begin
    ctl.op   = plb_pkg::OP_HOLD;
    fill_nxt = fill_r;
    ovf      = 1'b0;
    if (apply_en) begin
      if (clear) begin
        fill_nxt = '0;
      end else if (item_qty != '0) begin
        if (any_eq) begin
          ctl.op = plb_pkg::OP_WRITE;
        end else if (full) begin
          ovf = 1'b1;
        end else begin
          ctl.op   = plb_pkg::OP_INSERT;
          fill_nxt = fill_r + 1'b1;
        end
      end else if (any_eq) begin
        ctl.op   = plb_pkg::OP_DELETE;
        fill_nxt = fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
    logic                  prev_ahead;
    logic [PRICE_BITS-1:0] prev_price, next_price;
    logic [QTY_BITS-1:0]   prev_qty, next_qty;

    assign valid_v[i] = (32'(fill_r) > i);

    if (i == 0) begin : g_head
      assign prev_ahead = 1'b1;
      assign prev_price = item_price;
      assign prev_qty   = item_qty;
    end else begin : g_body
      assign prev_ahead = ahead_v[i-1];
      assign prev_price = price_v[i-1];
      assign prev_qty   = qty_v[i-1];
    end

    if (i == MAX_LEVELS - 1) begin : g_tail
      assign next_price = price_v[i];
      assign next_qty   = qty_v[i];
    end else begin : g_link
      assign next_price = price_v[i+1];
      assign next_qty   = qty_v[i+1];
    end

    plb_cell #(
      .PRICE_BITS(PRICE_BITS),
      .QTY_BITS  (QTY_BITS),
      .ASCEND    (ASCEND)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmp_en    (cmp_en),
      .cmp_price (cmp_price),
      .valid     (valid_v[i]),
      .ctl       (ctl),
      .new_price (item_price),
      .new_qty   (item_qty),
      .prev_ahead(prev_ahead),
      .prev_price(prev_price),
      .prev_qty  (prev_qty),
      .next_price(next_price),
      .next_qty  (next_qty),
      .price     (price_v[i]),
      .qty       (qty_v[i]),
      .ahead     (ahead_v[i]),
      .eq        (eq_v[i])
    );
  end

  assign fill       = fill_r;
  assign best_price = price_v[0];
  assign best_qty   = qty_v[0];

endmodule

`default_nettype wire

>>> rtl/price_level_book_top.sv
// ----------------------------------------------------------------------------
// price_level_book_top: bid and ask price level tables with best-level report
// flow: the cells compare against the incoming price in the accept cycle,
//   shift in the apply state, and the result loads in the report state once
//   the output slot is free; the next word is taken in that report step or idle
// reset: synchronous active-low rst_n empties both sides and drops any result;
//   the level storage itself is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module price_level_book_top #(
  parameter int unsigned MAX_LEVELS = plb_pkg::MAX_LEVELS_DEF,
  parameter int unsigned PRICE_BITS = plb_pkg::PRICE_BITS_DEF,
  parameter int unsigned QTY_BITS   = plb_pkg::QTY_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_mode,
  input  wire logic                          in_book_side,
  input  wire logic [plb_pkg::FIELD_W-1:0]   in_level_price,
  input  wire logic [plb_pkg::FIELD_W-1:0]   in_level_qty,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_bid_valid,
  output logic [plb_pkg::FIELD_W-1:0]        out_best_bid_price,
  output logic [plb_pkg::FIELD_W-1:0]        out_best_bid_qty,
  output logic                               out_ask_valid,
  output logic [plb_pkg::FIELD_W-1:0]        out_best_ask_price,
  output logic [plb_pkg::FIELD_W-1:0]        out_best_ask_qty,
  output logic [plb_pkg::COUNT_W-1:0]        out_bid_count,
  output logic [plb_pkg::COUNT_W-1:0]        out_ask_count,
  output logic                               out_overflow
);

  localparam int unsigned FILL_BITS = $clog2(MAX_LEVELS + 1);

  plb_pkg::state_t state_r, state_nxt;

  // held item, loaded at accept
  logic                  mode_r, side_r;
  logic [PRICE_BITS-1:0] price_r, cmp_price;
  logic [QTY_BITS-1:0]   qty_r;

  logic accept, slot_free, load_out, apply;
  logic ovf_r, ovf_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [FILL_BITS-1:0]  bid_fill, ask_fill;
  logic [PRICE_BITS-1:0] bid_price, ask_price;
  logic [QTY_BITS-1:0]   bid_qty, ask_qty;
  logic                  bid_ovf, ask_ovf;

  // result word registers
  logic                        bid_valid_r, ask_valid_r;
  logic [plb_pkg::FIELD_W-1:0] bid_price_r, bid_qty_r, ask_price_r, ask_qty_r;
  logic [plb_pkg::COUNT_W-1:0] bid_count_r, ask_count_r;
  logic                        overflow_r;

  // output slot can take a new word this cycle
  assign slot_free = !out_valid_r || !out_stall;

  // new word taken when idle, or while the previous result leaves the report step
  assign in_stall = !((state_r == plb_pkg::ST_IDLE) ||
                      ((state_r == plb_pkg::ST_REPORT) && slot_free));
  assign accept   = in_valid && !in_stall;

  // the cells compare against the incoming price in the accept cycle
  assign cmp_price = PRICE_BITS'(in_level_price);

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    apply     = 1'b0;
    case (state_r)
      plb_pkg::ST_IDLE: begin
        if (accept) state_nxt = plb_pkg::ST_APPLY;
      end
      plb_pkg::ST_APPLY: begin
        apply     = 1'b1;
        state_nxt = plb_pkg::ST_REPORT;
      end
      plb_pkg::ST_REPORT: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = accept ? plb_pkg::ST_APPLY : plb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = plb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item hold registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      side_r  <= in_book_side;
      price_r <= PRICE_BITS'(in_level_price);
      qty_r   <= QTY_BITS'(in_level_qty);
    end
  end

  // bids kept descending, asks ascending, so the best of each is in cell 0
  plb_side #(
    .MAX_LEVELS(MAX_LEVELS),
    .PRICE_BITS(PRICE_BITS),
    .QTY_BITS  (QTY_BITS),
    .ASCEND    (1'b0)
  ) u_bid (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmp_en    (accept && !in_book_side),
    .cmp_price (cmp_price),
    .apply_en  (apply && !side_r),
    .clear     (mode_r),
    .item_price(price_r),
    .item_qty  (qty_r),
    .fill      (bid_fill),
    .best_price(bid_price),
    .best_qty  (bid_qty),
    .ovf       (bid_ovf)
  );

  plb_side #(
    .MAX_LEVELS(MAX_LEVELS),
    .PRICE_BITS(PRICE_BITS),
    .QTY_BITS  (QTY_BITS),
    .ASCEND    (1'b1)
  ) u_ask (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmp_en    (accept && in_book_side),
    .cmp_price (cmp_price),
    .apply_en  (apply && side_r),
    .clear     (mode_r),
    .item_price(price_r),
    .item_qty  (qty_r),
    .fill      (ask_fill),
    .best_price(ask_price),
    .best_qty  (ask_qty),
    .ovf       (ask_ovf)
  );

  // overflow belongs to the item just applied only
  assign ovf_nxt = apply ? (bid_ovf | ask_ovf) : ovf_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // result word: empty sides read as zero, counts saturate at the field max
  always_ff @(posedge clk) begin
    if (load_out) begin
      bid_valid_r <= (bid_fill != '0);
      ask_valid_r <= (ask_fill != '0);
      bid_price_r <= (bid_fill != '0) ? plb_pkg::FIELD_W'(bid_price) : '0;
      bid_qty_r   <= (bid_fill != '0) ? plb_pkg::FIELD_W'(bid_qty) : '0;
      ask_price_r <= (ask_fill != '0) ? plb_pkg::FIELD_W'(ask_price) : '0;
      ask_qty_r   <= (ask_fill != '0) ? plb_pkg::FIELD_W'(ask_qty) : '0;
      bid_count_r <= (32'(bid_fill) > 32'(plb_pkg::COUNT_MAX)) ?
                     plb_pkg::COUNT_MAX : plb_pkg::COUNT_W'(bid_fill);
      ask_count_r <= (32'(ask_fill) > 32'(plb_pkg::COUNT_MAX)) ?
                     plb_pkg::COUNT_MAX : plb_pkg::COUNT_W'(ask_fill);
      overflow_r  <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bid_valid      = bid_valid_r;
  assign out_best_bid_price = bid_price_r;
  assign out_best_bid_qty   = bid_qty_r;
  assign out_ask_valid      = ask_valid_r;
  assign out_best_ask_price = ask_price_r;
  assign out_best_ask_qty   = ask_qty_r;
  assign out_bid_count      = bid_count_r;
  assign out_ask_count      = ask_count_r;
  assign out_overflow       = overflow_r;

  // level counts never run past the table depth
  a_bid_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(bid_fill) <= MAX_LEVELS)
    else $error("bid fill count beyond table depth");

  a_ask_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ask_fill) <= MAX_LEVELS)
    else $error("ask fill count beyond table depth");

  // every accepted word goes through the shift step next cycle
  a_accept_apply: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == plb_pkg::ST_APPLY))
    else $error("accepted word not applied");

  // a shown result word agrees with its own count
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((bid_valid_r == (bid_count_r != '0)) &&
                     (ask_valid_r == (ask_count_r != '0))))
    else $error("result valid bits disagree with counts");

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for price_level_book_top
// drives level updates and side clears through the valid/stall input channel
// and scores every result word against a behavioral book model kept in the
// bench; runs a directed table, then random update streams under several
// sender and receiver idling mixes, including a long receiver hold-off
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned MAX_LVL     = plb_pkg::MAX_LEVELS_DEF;
  localparam int unsigned FW          = plb_pkg::FIELD_W;
  localparam int unsigned CW          = plb_pkg::COUNT_W;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // item codes
  localparam bit MODE_APPLY = 1'b0;
  localparam bit MODE_CLEAR = 1'b1;
  localparam bit SIDE_BID   = 1'b0;
  localparam bit SIDE_ASK   = 1'b1;

  // one result word, field for field
  typedef struct packed {
    logic          bid_valid;
    logic [FW-1:0] best_bid_price;
    logic [FW-1:0] best_bid_qty;
    logic          ask_valid;
    logic [FW-1:0] best_ask_price;
    logic [FW-1:0] best_ask_qty;
    logic [CW-1:0] bid_count;
    logic [CW-1:0] ask_count;
    logic          overflow;
  } book_top_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct {
    bit            mode;
    bit            side;
    logic [FW-1:0] price;
    logic [FW-1:0] qty;
    bit            typed;
    book_top_t     top;
  } stim_row_t;

  logic          clk            = 1'b0;
  logic          rst_n          = 1'b0;
  logic          in_valid       = 1'b0;
  logic          in_stall;
  logic          in_mode        = 1'b0;
  logic          in_book_side   = 1'b0;
  logic [FW-1:0] in_level_price = '0;
  logic [FW-1:0] in_level_qty   = '0;
  logic          out_valid;
  logic          out_stall      = 1'b0;
  logic          out_bid_valid;
  logic [FW-1:0] out_best_bid_price;
  logic [FW-1:0] out_best_bid_qty;
  logic          out_ask_valid;
  logic [FW-1:0] out_best_ask_price;
  logic [FW-1:0] out_best_ask_qty;
  logic [CW-1:0] out_bid_count;
  logic [CW-1:0] out_ask_count;
  logic          out_overflow;

  price_level_book_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_book_side       (in_book_side),
    .in_level_price     (in_level_price),
    .in_level_qty       (in_level_qty),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bid_valid      (out_bid_valid),
    .out_best_bid_price (out_best_bid_price),
    .out_best_bid_qty   (out_best_bid_qty),
    .out_ask_valid      (out_ask_valid),
    .out_best_ask_price (out_best_ask_price),
    .out_best_ask_qty   (out_best_ask_qty),
    .out_bid_count      (out_bid_count),
    .out_ask_count      (out_ask_count),
    .out_overflow       (out_overflow)
  );

  always #4 clk = ~clk;

  // bench copy of both books, index 0 is bids, index 1 is asks
  logic [FW-1:0] lvl_px   [2][MAX_LVL];
  logic [FW-1:0] lvl_lots [2][MAX_LVL];
  int unsigned   lvl_n    [2] = '{0, 0};

  // results still owed by the block, oldest first
  book_top_t     book_q[$];

  // idling knobs, percent per cycle
  int unsigned   src_idle_pct   = 0;
  int unsigned   sink_stall_pct = 0;
  // long receiver hold-off, counted down by the stall process
  int unsigned   stall_hold     = 0;

  int unsigned   n_err           = 0;
  int unsigned   words_sent      = 0;
  int unsigned   results_checked = 0;
  int unsigned   drops_seen      = 0;
  int unsigned   cyc_count       = 0;

  // directed table: reset state, extremes, overwrite, delete, clear
  stim_row_t dir_rows [0:19] = '{
    // empty book right after reset
    '{MODE_CLEAR, SIDE_BID, 32'h0, 32'h0, 1'b1, '0},
    '{MODE_CLEAR, SIDE_ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0},
    // top price and top qty on the bid side
    '{MODE_APPLY, SIDE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      {1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 6'd1, 6'd0, 1'b0}},
    // zero price on the ask side
    '{MODE_APPLY, SIDE_ASK, 32'h0, 32'h1, 1'b1,
      {1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h1, 6'd1, 6'd1, 1'b0}},
    // lower bid goes behind the best
    '{MODE_APPLY, SIDE_BID, 32'd100, 32'd5, 1'b1,
      {1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h1, 6'd2, 6'd1, 1'b0}},
    // overwrite of the best bid
    '{MODE_APPLY, SIDE_BID, 32'hFFFF_FFFF, 32'd7, 1'b1,
      {1'b1, 32'hFFFF_FFFF, 32'h7, 1'b1, 32'h0, 32'h1, 6'd2, 6'd1, 1'b0}},
    '{MODE_APPLY, SIDE_ASK, 32'd1000, 32'd3, 1'b0, '0},
    '{MODE_APPLY, SIDE_ASK, 32'h0, 32'd9, 1'b0, '0},
    // delete of a price that is not held
    '{MODE_APPLY, SIDE_BID, 32'd55, 32'h0, 1'b0, '0},
    '{MODE_APPLY, SIDE_BID, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
    '{MODE_APPLY, SIDE_ASK, 32'h0, 32'h0, 1'b0, '0},
    // clear ignores price and qty
    '{MODE_CLEAR, SIDE_ASK, 32'hDEAD_BEEF, 32'h1234_5678, 1'b0, '0},
    '{MODE_APPLY, SIDE_ASK, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{MODE_APPLY, SIDE_ASK, 32'h7FFF_FFFF, 32'h1, 1'b0, '0},
    '{MODE_APPLY, SIDE_BID, 32'h0, 32'hFFFF_FFFF, 1'b0, '0},
    '{MODE_APPLY, SIDE_BID, 32'd100, 32'h0, 1'b0, '0},
    // last bid removed, side goes empty
    '{MODE_APPLY, SIDE_BID, 32'h0, 32'h0, 1'b0, '0},
    // delete on an empty side
    '{MODE_APPLY, SIDE_BID, 32'h1, 32'h0, 1'b0, '0},
    '{MODE_CLEAR, SIDE_BID, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
    '{MODE_APPLY, SIDE_ASK, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0}
  };

  // apply one update to the bench book and return the word it should report
  function automatic book_top_t book_update(bit mode, bit side,
                                            logic [FW-1:0] price, logic [FW-1:0] qty);
    int unsigned n, i, k;
    book_top_t   top;
    top = '0;
    n   = lvl_n[side];
    if (mode == MODE_CLEAR) begin
      lvl_n[side] = 0;
    end else if (qty != 0) begin
      // sorted by descending price: skip every higher price
      i = 0;
      while (i < n && lvl_px[side][i] > price) i++;
      if (i < n && lvl_px[side][i] == price) begin
        lvl_lots[side][i] = qty;
      end else if (n >= MAX_LVL) begin
        top.overflow = 1'b1;
      end else begin
        for (k = n; k > i; k--) begin
          lvl_px[side][k]   = lvl_px[side][k-1];
          lvl_lots[side][k] = lvl_lots[side][k-1];
        end
        lvl_px[side][i]   = price;
        lvl_lots[side][i] = qty;
        lvl_n[side]       = n + 1;
      end
    end else begin
      i = 0;
      while (i < n && lvl_px[side][i] != price) i++;
      if (i < n) begin
        for (k = i; k + 1 < n; k++) begin
          lvl_px[side][k]   = lvl_px[side][k+1];
          lvl_lots[side][k] = lvl_lots[side][k+1];
        end
        lvl_n[side] = n - 1;
      end
    end
    if (lvl_n[0] != 0) begin
      top.bid_valid      = 1'b1;
      top.best_bid_price = lvl_px[0][0];
      top.best_bid_qty   = lvl_lots[0][0];
    end
    if (lvl_n[1] != 0) begin
      top.ask_valid      = 1'b1;
      top.best_ask_price = lvl_px[1][lvl_n[1]-1];
      top.best_ask_qty   = lvl_lots[1][lvl_n[1]-1];
    end
    top.bid_count = CW'(lvl_n[0]);
    top.ask_count = CW'(lvl_n[1]);
    return top;
  endfunction

  // offer one word, hold it until taken, then book what it should report
  task automatic send_update(bit mode, bit side, logic [FW-1:0] price,
                             logic [FW-1:0] qty, bit typed, book_top_t typed_top);
    book_top_t pred;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_book_side   <= side;
    in_level_price <= price;
    in_level_qty   <= qty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = book_update(mode, side, price, qty);
    book_q.insert(book_q.size(), typed ? typed_top : pred);
    words_sent++;
    if (pred.overflow) drops_seen++;
  endtask

  // clear a side, fill it past capacity, then touch held levels
  task automatic fill_side(bit side);
    int unsigned k, extra;
    extra = $urandom_range(4, 1);
    send_update(MODE_CLEAR, side, $urandom(), $urandom(), 1'b0, '0);
    for (k = 0; k < MAX_LVL + extra; k++)
      send_update(MODE_APPLY, side, $urandom(), $urandom() | 32'h1, 1'b0, '0);
    repeat (6)
      send_update(MODE_APPLY, side, lvl_px[side][$urandom_range(lvl_n[side] - 1, 0)],
                  $urandom(), 1'b0, '0);
  endtask

  // mostly well-formed updates against held prices, some noise
  task automatic send_random_update();
    int unsigned   sd, n, pick;
    logic [FW-1:0] p, q;
    bit            m;
    sd   = $urandom_range(1, 0);
    n    = lvl_n[sd];
    pick = $urandom_range(99, 0);
    m    = MODE_APPLY;
    p    = $urandom();
    q    = $urandom();
    if (q == 0) q = 1;
    if (pick < 12) begin
      // noise: any field values, occasional clear
      if ($urandom_range(7, 0) == 0) m = MODE_CLEAR;
      q = $urandom();
    end else if (pick < 14) begin
      m = MODE_CLEAR;
    end else if (pick < 34 && n > 0) begin
      // overwrite a held level
      p = lvl_px[sd][$urandom_range(n - 1, 0)];
    end else if (pick < 52 && n > 0) begin
      // delete a held level
      p = lvl_px[sd][$urandom_range(n - 1, 0)];
      q = '0;
    end else if (pick < 57) begin
      // delete of a price most likely absent
      q = '0;
    end else begin
      // new level: narrow range for collisions, extremes, or anywhere
      case ($urandom_range(3, 0))
        0:       p = $urandom_range(255, 0);
        1:       p = $urandom_range(1, 0) ? '1 : '0;
        default: p = $urandom();
      endcase
    end
    send_update(m, sd[0], p, q, 1'b0, '0);
  endtask

  // hold the sender until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (book_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [FW-1:0] want, logic [FW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_err++;
    end
  endtask

  // receiver: random stall, or a long counted hold-off when asked
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      out_stall  <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < sink_stall_pct);
    end
  end

  // result scoreboard, sampled on the values before the edge
  always @(posedge clk) begin
    book_top_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (book_q.size() == 0) begin
        $error("result word with no update pending");
        n_err++;
      end else begin
        want = book_q.pop_front();
        check_field("bid_valid", FW'(want.bid_valid), FW'(out_bid_valid));
        check_field("best_bid_price", want.best_bid_price, out_best_bid_price);
        check_field("best_bid_qty", want.best_bid_qty, out_best_bid_qty);
        check_field("ask_valid", FW'(want.ask_valid), FW'(out_ask_valid));
        check_field("best_ask_price", want.best_ask_price, out_best_ask_price);
        check_field("best_ask_qty", want.best_ask_qty, out_best_ask_qty);
        check_field("bid_count", FW'(want.bid_count), FW'(out_bid_count));
        check_field("ask_count", FW'(want.ask_count), FW'(out_ask_count));
        check_field("overflow", FW'(want.overflow), FW'(out_overflow));
        results_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int unsigned r, ph;
    // reset once, held low and then released
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (r = 0; r < 20; r++)
      send_update(dir_rows[r].mode, dir_rows[r].side, dir_rows[r].price,
                  dir_rows[r].qty, dir_rows[r].typed, dir_rows[r].top);
    wait_drained();

    // random phases: no idling, sender idle, receiver stall, both
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 64; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 64; end
        default: begin src_idle_pct = 33; sink_stall_pct = 33; end
      endcase
      // first phase: receiver holds off while the sender keeps offering
      if (ph == 0) stall_hold = 300;
      fill_side(SIDE_BID);
      fill_side(SIDE_ASK);
      repeat (250) send_random_update();
      // sender pauses until the block has answered everything
      wait_drained();
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);

    $display("sent %0d update words, checked %0d result words", words_sent,
             results_checked);
    $display("full-side drops seen: %0d, under four idling mixes", drops_seen);
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
